>>> hdl/iphl_pkg.sv
`timescale 1ns / 1ps
package iphl_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_FOUND    = 3'd2;
    localparam logic [2:0] ST_MISSING  = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;

    localparam logic [1:0] REG_TABLE_SIZE = 2'd0;
    localparam logic [1:0] REG_HASH_MULT  = 2'd1;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] address;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [9:0] bucket;
        logic [1:0] slot;
    } t_rsp;

    // hashed request between front and back, bucket wide enough for the largest table
    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] address;
        logic [15:0] bucket;
    } t_job;

endpackage

>>> hdl/iphl_front.sv
`timescale 1ns / 1ps
module iphl_front #(
    parameter int BUCKETS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    output logic                o_ready,
    input  iphl_pkg::t_req      i_req,
    input  logic [10:0]         i_table_size,
    input  logic [31:0]         i_hash_mult,
    output logic                o_job_valid,
    input  logic                i_job_ready,
    output iphl_pkg::t_job      o_job
);
    import iphl_pkg::*;

    localparam int MW = $clog2(BUCKETS + 1);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_DIV  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]    r_state, n_state;
    t_req          r_req;
    logic [31:0]   r_prod;
    logic [MW-1:0] r_mod;
    logic [MW-1:0] r_rem;
    logic [4:0]    r_cnt;
    logic [MW:0]   w_sh;
    logic [MW-1:0] w_rem;
    logic [MW-1:0] w_mod;

    // modulus saturated to 1..BUCKETS
    always_comb begin
        if (i_table_size == 11'd0) begin
            w_mod = MW'(1);
        end else if (32'(i_table_size) > 32'(BUCKETS)) begin
            w_mod = MW'(BUCKETS);
        end else begin
            w_mod = MW'(i_table_size);
        end
    end

    // one restoring step per cycle
    assign w_sh  = {r_rem, r_prod[31]};
    assign w_rem = (w_sh >= {1'b0, r_mod}) ? MW'(w_sh - {1'b0, r_mod}) : MW'(w_sh);

    assign o_ready     = (r_state == F_IDLE) && i_en;
    assign o_job_valid = (r_state == F_PUSH);
    assign o_job       = '{command: r_req.command, address: r_req.address,
                           bucket: 16'(r_rem)};

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: if (i_valid && o_ready) begin
                n_state = (i_req.command == CMD_CLEAR) ? F_PUSH : F_MUL;
            end
            F_MUL:  n_state = F_DIV;
            F_DIV:  if (r_cnt == 5'd31) begin
                n_state = F_PUSH;
            end
            F_PUSH: if (i_job_ready) begin
                n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        case (r_state)
            F_IDLE: begin
                r_req <= i_req;
                r_rem <= '0;
                r_cnt <= '0;
            end
            F_MUL: begin
                r_prod <= 32'(r_req.address * i_hash_mult);
                r_mod  <= w_mod;
            end
            F_DIV: begin
                r_rem  <= w_rem;
                r_prod <= {r_prod[30:0], 1'b0};
                r_cnt  <= r_cnt + 5'd1;
            end
            default: ;
        endcase
    end

endmodule

>>> hdl/iphl_fifo.sv
`timescale 1ns / 1ps
module iphl_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  iphl_pkg::t_job i_data,
    input  logic           i_pop,
    output logic           o_empty,
    output iphl_pkg::t_job o_data
);
    import iphl_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= ~r_wp;
            end
            if (i_pop && !o_empty) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_pop && !o_empty);
        end
    end

endmodule

>>> hdl/iphl_back.sv
`timescale 1ns / 1ps
module iphl_back #(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  iphl_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_init_done,
    output logic           o_valid,
    input  logic           i_ready,
    output iphl_pkg::t_rsp o_rsp
);
    import iphl_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FW = $clog2(WAYS + 1);
    localparam int AW = (BUCKETS * WAYS > 1) ? $clog2(BUCKETS * WAYS) : 1;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_FILL = 3'd1;
    localparam logic [2:0] B_CMP  = 3'd2;
    localparam logic [2:0] B_OUT  = 3'd3;
    localparam logic [2:0] B_CLR  = 3'd4;

    logic [FW-1:0] r_fill_mem [BUCKETS];
    logic [31:0]   r_addr_mem [BUCKETS * WAYS];

    logic [2:0]    r_state;
    logic          r_init;
    t_job          r_job;
    logic [FW-1:0] r_fill_rd;
    logic [31:0]   r_addr_rd;
    logic [WW-1:0] r_way;
    logic [BW-1:0] r_clr;
    t_rsp          r_rsp;
    logic [BW-1:0] w_bkt;
    logic [AW-1:0] w_rd_idx;
    logic [WW-1:0] w_rd_way;
    logic          w_rd_en;

    function automatic logic [AW-1:0] slot_idx(input logic [BW-1:0] b, input logic [WW-1:0] w);
        slot_idx = AW'(32'(b) * WAYS + 32'(w));
    endfunction

    assign w_bkt       = r_job.bucket[BW-1:0];
    assign o_pop       = (r_state == B_IDLE) && !i_empty;
    assign o_init_done = !r_init;
    assign o_valid     = (r_state == B_OUT);
    assign o_rsp       = r_rsp;

    // slot read: first slot after a nonzero fill count on a lookup, following ones while comparing
    always_comb begin
        w_rd_en  = 1'b0;
        w_rd_way = '0;
        if (r_state == B_FILL && r_job.command != CMD_INSERT && r_fill_rd != '0) begin
            w_rd_en = 1'b1;
        end else if (r_state == B_CMP) begin
            w_rd_en  = 1'b1;
            w_rd_way = WW'(r_way + WW'(1));
        end
        w_rd_idx = slot_idx(w_bkt, w_rd_way);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_fill_rd <= r_fill_mem[i_job.bucket[BW-1:0]];
        end
        if (w_rd_en) begin
            r_addr_rd <= r_addr_mem[w_rd_idx];
        end
        if (r_state == B_CLR) begin
            r_fill_mem[r_clr] <= '0;
        end else if (r_state == B_FILL && r_job.command == CMD_INSERT
                     && 32'(r_fill_rd) < WAYS) begin
            r_fill_mem[w_bkt] <= FW'(r_fill_rd + FW'(1));
            r_addr_mem[slot_idx(w_bkt, WW'(r_fill_rd))] <= r_job.address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLR;
            r_init  <= 1'b1;
            r_clr   <= '0;
        end else begin
            case (r_state)
                B_IDLE: if (o_pop) begin
                    r_job   <= i_job;
                    r_clr   <= '0;
                    r_state <= (i_job.command == CMD_CLEAR) ? B_CLR : B_FILL;
                end
                B_FILL: begin
                    r_rsp.bucket <= 10'(w_bkt);
                    r_rsp.slot   <= '0;
                    r_way        <= '0;
                    if (r_job.command == CMD_INSERT) begin
                        if (32'(r_fill_rd) < WAYS) begin
                            r_rsp.status <= ST_INSERTED;
                            r_rsp.slot   <= 2'(r_fill_rd);
                        end else begin
                            r_rsp.status <= ST_FULL;
                        end
                        r_state <= B_OUT;
                    end else if (r_fill_rd == '0) begin
                        r_rsp.status <= ST_MISSING;
                        r_state      <= B_OUT;
                    end else begin
                        r_state <= B_CMP;
                    end
                end
                B_CMP: begin
                    if (r_addr_rd == r_job.address) begin
                        r_rsp.status <= ST_FOUND;
                        r_rsp.slot   <= 2'(r_way);
                        r_state      <= B_OUT;
                    end else if (FW'(r_way) + FW'(1) == r_fill_rd) begin
                        r_rsp.status <= ST_MISSING;
                        r_state      <= B_OUT;
                    end else begin
                        r_way <= WW'(r_way + WW'(1));
                    end
                end
                B_OUT: if (i_ready) begin
                    r_state <= B_IDLE;
                end
                B_CLR: begin
                    r_clr <= BW'(r_clr + BW'(1));
                    if (32'(r_clr) == BUCKETS - 1) begin
                        r_rsp   <= '{status: ST_CLEARED, bucket: 10'd0, slot: 2'd0};
                        r_init  <= 1'b0;
                        r_state <= r_init ? B_IDLE : B_OUT;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    a_no_pop_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !o_pop)
        else $error("request taken during initial sweep");
    a_clear_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_rsp.status == ST_CLEARED) |-> (r_rsp.bucket == 10'd0 && r_rsp.slot == 2'd0))
        else $error("clear response carries bucket or slot");
    a_cmp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CMP) |-> (FW'(r_way) < r_fill_rd))
        else $error("compare past fill count");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_rsp)))
        else $error("response dropped while stalled");

endmodule

>>> hdl/ipv4_hash_table_lookup_unit.sv
`timescale 1ns / 1ps
// insert/lookup: multiply, serial modulo in the front, then fill-count read and slot write or compares in the back
// requests: the front takes a new request only once the last one is pushed; its modulo works one bit per cycle
// clear: the back zeroes one fill-count entry per cycle over all buckets, then gives the cleared response
// reset: synchronous active low; a sweep zeroes the fill counts, no request
// is taken until it ends, configuration writes are taken at once
module ipv4_hash_table_lookup_unit #(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // request channel
    input  logic           i_valid,
    output logic           o_ready,
    input  iphl_pkg::t_req i_req,
    // response channel
    output logic           o_valid,
    input  logic           i_ready,
    output iphl_pkg::t_rsp o_rsp,
    // configuration writes
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data
);
    import iphl_pkg::*;

    // configuration registers
    logic [10:0] r_table_size;
    logic [31:0] r_hash_mult;

    // front to queue to back
    logic w_job_valid, w_full, w_empty, w_pop, w_init_done;
    t_job w_job_in, w_job_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= 11'd1024;
            r_hash_mult  <= 32'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TABLE_SIZE: r_table_size <= i_cfg_data[10:0];
                REG_HASH_MULT:  r_hash_mult  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: takes requests, hashes the address with the serial modulo
    iphl_front #(.BUCKETS(BUCKETS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_init_done),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req        (i_req),
        .i_table_size (r_table_size),
        .i_hash_mult  (r_hash_mult),
        .o_job_valid  (w_job_valid),
        .i_job_ready  (!w_full),
        .o_job        (w_job_in)
    );

    // two-entry queue so front and back stall independently
    iphl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_valid),
        .o_full  (w_full),
        .i_data  (w_job_in),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_job_out)
    );

    // back: bucket tables, slot compare and response register
    iphl_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_job       (w_job_out),
        .o_pop       (w_pop),
        .o_init_done (w_init_done),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rsp       (o_rsp)
    );

endmodule
